// ===== sv/blr_pkg.sv =====
// Shared constants for the Bresenham line rasteriser: dimension limits,
// state widths, register indexes and request codes.
// No dependencies.
`timescale 1ns / 1ps

package blr_pkg;

    // Screen dimension limit and the widths that follow from it
    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int MAG_W       = $clog2(MAX_DIM);
    localparam int COLOR_BITS  = 32;

    // Field and state widths
    localparam int COORD_W     = 16;
    localparam int ADDR_W      = 24;
    localparam int CFG_W       = 13;
    localparam int ERR_W       = 15;
    localparam int LEFT_W      = 13;
    localparam int TWICE_W     = 14;
    localparam int PIX_COLOR_W = 32;
    localparam int PDATA_W     = 32;
    localparam int PADDR_W     = 3;

    // Register indexes (word address bit 2)
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // Request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

endpackage

// ===== sv/bresenham_line_rasterizer.sv =====
// Top level of the Bresenham line rasteriser: configuration registers,
// line set-up, per-pixel stepping and the output register.
// Depends on blr_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): a start transaction (req_type = 0)
//   carries both endpoints and a colour; it is checked against the screen
//   size, latched and gives no output. A step transaction (req_type = 1)
//   gives one pixel write, flagged last_pixel on the final pixel; a step
//   while no line is active gives nothing. A start abandons any line.
//   Output channel (out_valid/out_ready): pixel_index = x + y * width,
//   pixel_color and last_pixel, held in one output register.
//   Latency: out_valid rises in the cycle after an accepted step. Throughput:
//   one transaction per cycle unless stalled, set by the single output
//   register; the set-up multiply and error-term update are combinational.
//   A step may follow a start in the very next cycle.
//   Stall: while out_valid is high and out_ready low, in_ready is low; the
//   input is taken again in the cycle the pending pixel is taken.
//   Reset: asynchronous, active low; width 640, height 480, no line active,
//   output empty. The user must configure via the APB port only while idle; unenforced.
module bresenham_line_rasterizer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [blr_pkg::PADDR_W-1:0]          paddr,
    input  logic [blr_pkg::PDATA_W-1:0]          pwdata,
    output logic [blr_pkg::PDATA_W-1:0]          prdata,
    output logic                                 pready,
    // Request channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 req_type,
    input  logic signed [blr_pkg::COORD_W-1:0]   start_x,
    input  logic signed [blr_pkg::COORD_W-1:0]   start_y,
    input  logic signed [blr_pkg::COORD_W-1:0]   end_x,
    input  logic signed [blr_pkg::COORD_W-1:0]   end_y,
    input  logic [blr_pkg::PIX_COLOR_W-1:0]      line_color,
    // Pixel channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [blr_pkg::ADDR_W-1:0]           pixel_index,
    output logic [blr_pkg::PIX_COLOR_W-1:0]      pixel_color,
    output logic                                 last_pixel
);

    import blr_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0]       width_reg;
    logic [CFG_W-1:0]       height_reg;

    // Line state
    logic                   busy_reg;
    logic [ADDR_W-1:0]      cur_addr_reg;
    logic [ERR_W-1:0]       err_term_reg;
    logic [LEFT_W-1:0]      pixels_left_reg;
    logic [TWICE_W-1:0]     major_twice_reg;
    logic [TWICE_W-1:0]     minor_twice_reg;
    logic                   x_major_reg;
    logic                   x_negative_reg;
    logic                   y_negative_reg;
    logic [COLOR_BITS-1:0]  held_color_reg;

    // Output register
    logic                   out_valid_reg;
    logic [ADDR_W-1:0]      pixel_index_reg;
    logic [PIX_COLOR_W-1:0] pixel_color_reg;
    logic                   last_pixel_reg;

    logic                   cfg_write;
    logic                   in_take;
    logic                   start_take;
    logic                   step_take;

    logic [DIM_W-1:0]       w_clamp;
    logic [DIM_W-1:0]       h_clamp;
    logic                   start_on;
    logic                   end_on;
    logic                   line_ok;

    logic [COORD_W:0]       dx;
    logic [COORD_W:0]       dy;
    logic                   dx_neg;
    logic                   dy_neg;
    logic [COORD_W:0]       adx_full;
    logic [COORD_W:0]       ady_full;
    logic [MAG_W-1:0]       adx;
    logic [MAG_W-1:0]       ady;
    logic                   x_major_next;
    logic [MAG_W-1:0]       major;
    logic [MAG_W-1:0]       minor;
    logic [TWICE_W-1:0]     major_twice_next;
    logic [TWICE_W-1:0]     minor_twice_next;
    logic [ERR_W-1:0]       err_start;
    logic [LEFT_W-1:0]      pixels_left_start;
    logic [ADDR_W:0]        row_base;
    logic [ADDR_W-1:0]      addr_start;

    logic [ADDR_W-1:0]      x_step;
    logic [ADDR_W-1:0]      y_step;
    logic [ADDR_W-1:0]      major_step;
    logic [ADDR_W-1:0]      minor_step;
    logic                   err_ge;
    logic [ERR_W-1:0]       err_adj;
    logic [ERR_W-1:0]       err_step;
    logic [ADDR_W-1:0]      addr_step;
    logic                   step_last;

    // APB access: always ready, write in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        if (paddr[2] == REG_HEIGHT)
            prdata = PDATA_W'(height_reg);
        else
            prdata = PDATA_W'(width_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_WIDTH)
                width_reg <= pwdata[CFG_W-1:0];
            else
                height_reg <= pwdata[CFG_W-1:0];
        end
    end

    // Take a transaction whenever the output register is free or draining
    assign in_ready   = !out_valid_reg || out_ready;
    assign in_take    = in_valid && in_ready;
    assign start_take = in_take && (req_type == REQ_START);
    assign step_take  = in_take && (req_type == REQ_STEP) && busy_reg;

    // Clamp the screen size to the supported maximum
    assign w_clamp = (DIM_W'(width_reg) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                           : DIM_W'(width_reg);
    assign h_clamp = (DIM_W'(height_reg) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                            : DIM_W'(height_reg);

    // Reject the line if either endpoint lies off screen
    assign start_on = !start_x[COORD_W-1] && !start_y[COORD_W-1]
                      && (start_x < COORD_W'(w_clamp))
                      && (start_y < COORD_W'(h_clamp));
    assign end_on   = !end_x[COORD_W-1] && !end_y[COORD_W-1]
                      && (end_x < COORD_W'(w_clamp))
                      && (end_y < COORD_W'(h_clamp));
    assign line_ok  = start_on && end_on;

    // Deltas, directions and major axis
    assign dx       = {end_x[COORD_W-1], end_x} - {start_x[COORD_W-1], start_x};
    assign dy       = {end_y[COORD_W-1], end_y} - {start_y[COORD_W-1], start_y};
    assign dx_neg   = dx[COORD_W];
    assign dy_neg   = dy[COORD_W];
    assign adx_full = dx_neg ? (~dx + 1'b1) : dx;
    assign ady_full = dy_neg ? (~dy + 1'b1) : dy;
    assign adx      = adx_full[MAG_W-1:0];
    assign ady      = ady_full[MAG_W-1:0];

    assign x_major_next      = adx > ady;
    assign major             = x_major_next ? adx : ady;
    assign minor             = x_major_next ? ady : adx;
    assign major_twice_next  = TWICE_W'({major, 1'b0});
    assign minor_twice_next  = TWICE_W'({minor, 1'b0});
    assign err_start         = ERR_W'(minor_twice_next) - ERR_W'(major);
    assign pixels_left_start = LEFT_W'(major) + 1'b1;

    // Start address: x0 + y0 * width, wrapped to the address width
    assign row_base   = (ADDR_W + 1)'(start_y[MAG_W-1:0]) * (ADDR_W + 1)'(w_clamp);
    assign addr_start = ADDR_W'(row_base + (ADDR_W + 1)'(start_x[MAG_W-1:0]));

    // Step directions in address space
    assign x_step     = x_negative_reg ? {ADDR_W{1'b1}} : ADDR_W'(1);
    assign y_step     = y_negative_reg ? (ADDR_W'(0) - ADDR_W'(w_clamp))
                                       : ADDR_W'(w_clamp);
    assign major_step = x_major_reg ? x_step : y_step;
    assign minor_step = x_major_reg ? y_step : x_step;

    // Advance the error term and the address by one pixel
    assign err_ge    = !err_term_reg[ERR_W-1];
    assign err_adj   = err_ge ? (err_term_reg - ERR_W'(major_twice_reg)) : err_term_reg;
    assign err_step  = err_adj + ERR_W'(minor_twice_reg);
    assign addr_step = cur_addr_reg + (err_ge ? minor_step : ADDR_W'(0)) + major_step;
    assign step_last = pixels_left_reg <= LEFT_W'(1);

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            cur_addr_reg    <= '0;
            err_term_reg    <= '0;
            pixels_left_reg <= '0;
            major_twice_reg <= '0;
            minor_twice_reg <= '0;
            x_major_reg     <= 1'b0;
            x_negative_reg  <= 1'b0;
            y_negative_reg  <= 1'b0;
            held_color_reg  <= '0;
        end
        else if (start_take)
        begin
            busy_reg <= line_ok;
            if (line_ok)
            begin
                cur_addr_reg    <= addr_start;
                err_term_reg    <= err_start;
                pixels_left_reg <= pixels_left_start;
                major_twice_reg <= major_twice_next;
                minor_twice_reg <= minor_twice_next;
                x_major_reg     <= x_major_next;
                x_negative_reg  <= dx_neg;
                y_negative_reg  <= dy_neg;
                held_color_reg  <= COLOR_BITS'(line_color);
            end
        end
        else if (step_take)
        begin
            cur_addr_reg <= addr_step;
            err_term_reg <= err_step;
            if (step_last)
            begin
                pixels_left_reg <= '0;
                busy_reg        <= 1'b0;
            end
            else
            begin
                pixels_left_reg <= pixels_left_reg - 1'b1;
            end
        end
    end

    // Output register: load on a step, drop when the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_take)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_take)
        begin
            pixel_index_reg <= cur_addr_reg;
            pixel_color_reg <= PIX_COLOR_W'(held_color_reg);
            last_pixel_reg  <= step_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_index = pixel_index_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

endmodule
